FILE: hw/rtl/mtks_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mtks_pkg
// Shared command and status types between the keystream controller and the
// keystream datapath.
// ---------------------------------------------------------------------------
package mtks_pkg;

   // one command per cycle from the controller to the datapath
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_EMIT_DIRECT,
      OP_EMIT_HELD,
      OP_SEED_INIT,
      OP_SEED_MUL0,
      OP_SEED_MUL1,
      OP_SEED_MUL2,
      OP_SEED_MUL3,
      OP_FETCH0,
      OP_FETCH1,
      OP_FETCH2,
      OP_FETCH3,
      OP_FETCH4
   } op_type;

   typedef struct packed {
      logic have_word;  // current word still has unused keystream bytes
      logic seed_last;  // seeding is on the final state word
      logic rsp_free;   // result register can take a value this cycle
      logic held_last;  // last flag of the captured transaction
   } status_type;

endpackage
`default_nettype wire

FILE: hw/rtl/mtks_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mtks_ctrl
// Controller: sequences reseeding, word generation and result emission.
// ---------------------------------------------------------------------------
module mtks_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   input  wire logic                req_tlast,
   output logic                     req_tready,
   input  wire mtks_pkg::status_type status,
   output mtks_pkg::op_type         op
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEED_INIT,
      S_SEED_MUL0,
      S_SEED_MUL1,
      S_SEED_MUL2,
      S_SEED_MUL3,
      S_FETCH0,
      S_FETCH1,
      S_FETCH2,
      S_FETCH3,
      S_FETCH4,
      S_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      reseed_ff;
   logic      reseed_in;
   logic      take;

   assign take       = (state_ff == S_IDLE) && req_tvalid && status.rsp_free;
   assign req_tready = (state_ff == S_IDLE) && status.rsp_free;

   always_comb begin
      state_in  = state_ff;
      reseed_in = reseed_ff;
      op        = mtks_pkg::OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (take) begin
               if (reseed_ff) begin
                  op       = mtks_pkg::OP_CAPTURE;
                  state_in = S_SEED_INIT;
               end else if (!status.have_word) begin
                  op       = mtks_pkg::OP_CAPTURE;
                  state_in = S_FETCH0;
               end else begin
                  op = mtks_pkg::OP_EMIT_DIRECT;
                  if (req_tlast) begin
                     reseed_in = 1'b1;
                  end
               end
            end
         end
         S_SEED_INIT: begin
            op        = mtks_pkg::OP_SEED_INIT;
            reseed_in = 1'b0;
            state_in  = S_SEED_MUL0;
         end
         S_SEED_MUL0: begin
            op       = mtks_pkg::OP_SEED_MUL0;
            state_in = S_SEED_MUL1;
         end
         S_SEED_MUL1: begin
            op       = mtks_pkg::OP_SEED_MUL1;
            state_in = S_SEED_MUL2;
         end
         S_SEED_MUL2: begin
            op       = mtks_pkg::OP_SEED_MUL2;
            state_in = S_SEED_MUL3;
         end
         S_SEED_MUL3: begin
            op       = mtks_pkg::OP_SEED_MUL3;
            state_in = status.seed_last ? S_FETCH0 : S_SEED_MUL0;
         end
         S_FETCH0: begin
            op       = mtks_pkg::OP_FETCH0;
            state_in = S_FETCH1;
         end
         S_FETCH1: begin
            op       = mtks_pkg::OP_FETCH1;
            state_in = S_FETCH2;
         end
         S_FETCH2: begin
            op       = mtks_pkg::OP_FETCH2;
            state_in = S_FETCH3;
         end
         S_FETCH3: begin
            op       = mtks_pkg::OP_FETCH3;
            state_in = S_FETCH4;
         end
         S_FETCH4: begin
            op       = mtks_pkg::OP_FETCH4;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            op       = mtks_pkg::OP_EMIT_HELD;
            state_in = S_IDLE;
            if (status.held_last) begin
               reseed_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         reseed_ff <= 1'b1;
      end else begin
         state_ff  <= state_in;
         reseed_ff <= reseed_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/mtks_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mtks_datapath
// Twister state memory, shared seeding multiplier, in-place twist, tempering
// and the byte xor with the result register.
// ---------------------------------------------------------------------------
module mtks_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mtks_pkg::op_type    op,
   output mtks_pkg::status_type     status,
   input  wire logic [7:0]          req_tdata,
   input  wire logic                req_tlast,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [63:0]         csr_data,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [7:0]               rsp_tdata,
   output logic                     rsp_tlast
);

   localparam int unsigned       N_WORDS   = 312;
   localparam logic [8:0]        LAST_IDX  = 9'(N_WORDS - 1);
   localparam logic [8:0]        MID_OFS   = 9'd156;
   localparam logic [63:0]       MATRIX    = 64'hB502_6F5A_A966_19E9;
   localparam logic [63:0]       UPPER     = 64'hFFFF_FFFF_8000_0000;
   localparam logic [63:0]       LOWER     = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0]       INIT_MUL  = 64'h5851_F42D_4C95_7F2D;

   function automatic logic [63:0] temper(input logic [63:0] w);
      logic [63:0] y;
      y = w;
      y = y ^ ((y >> 29) & 64'h5555_5555_5555_5555);
      y = y ^ ((y << 17) & 64'h71D6_7FFF_EEDA_0000);
      y = y ^ ((y << 37) & 64'hFFF7_EEE0_0000_0000);
      y = y ^ (y >> 43);
      return y;
   endfunction

   // state memory, single port, registered read
   logic [63:0] mem [0:N_WORDS-1];
   logic [63:0] rdata_ff;
   logic        mem_we;
   logic [8:0]  mem_addr;
   logic [63:0] mem_wdata;

   logic [63:0] seed_ff,  seed_in;
   logic [63:0] prev_ff,  prev_in;
   logic [63:0] x_ff,     x_in;
   logic [63:0] prod_ff,  prod_in;
   logic [63:0] acc_ff,   acc_in;
   logic [8:0]  sidx_ff,  sidx_in;
   logic [8:0]  k_ff,     k_in;
   logic [63:0] a_ff,     a_in;
   logic [63:0] b_ff,     b_in;
   logic [63:0] tw_ff,    tw_in;
   logic [63:0] cur_ff,   cur_in;
   logic [3:0]  pos_ff,   pos_in;
   logic [7:0]  hold_data_ff, hold_data_in;
   logic        hold_last_ff, hold_last_in;
   logic [7:0]  rsp_data_ff,  rsp_data_in;
   logic        rsp_last_ff,  rsp_last_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] seed_x;
   logic [63:0] twist_x;
   logic [63:0] twist_xa;
   logic [8:0]  k_next;
   logic [8:0]  k_mid;
   logic [7:0]  emit_data;
   logic        emit_last;
   logic [7:0]  ks_byte;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign status.have_word = ~pos_ff[3];
   assign status.seed_last = (sidx_ff == LAST_IDX);
   assign status.rsp_free  = ~rsp_valid_ff | rsp_tready;
   assign status.held_last = hold_last_ff;

   assign seed_x   = prev_ff ^ (prev_ff >> 62);
   assign twist_x  = (a_ff & UPPER) | (b_ff & LOWER);
   assign twist_xa = (twist_x >> 1) ^ (twist_x[0] ? MATRIX : 64'h0);
   assign k_next   = (k_ff == LAST_IDX) ? 9'd0 : k_ff + 9'd1;
   assign k_mid    = (k_ff < MID_OFS) ? k_ff + MID_OFS : k_ff - MID_OFS;
   assign ks_byte  = cur_ff[{pos_ff[2:0], 3'b000} +: 8];
   assign prod_in  = mul_a * mul_b;

   always_comb begin
      seed_in      = seed_ff;
      prev_in      = prev_ff;
      x_in         = x_ff;
      acc_in       = acc_ff;
      sidx_in      = sidx_ff;
      k_in         = k_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      tw_in        = tw_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      hold_data_in = hold_data_ff;
      hold_last_in = hold_last_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      mem_we       = 1'b0;
      mem_addr     = k_ff;
      mem_wdata    = tw_ff;
      mul_a        = x_ff[31:0];
      mul_b        = INIT_MUL[31:0];
      emit_data    = hold_data_ff;
      emit_last    = hold_last_ff;

      if (csr_valid) begin
         seed_in = csr_data;
      end

      case (op)
         mtks_pkg::OP_CAPTURE: begin
            hold_data_in = req_tdata;
            hold_last_in = req_tlast;
         end
         mtks_pkg::OP_EMIT_DIRECT, mtks_pkg::OP_EMIT_HELD: begin
            if (op == mtks_pkg::OP_EMIT_DIRECT) begin
               emit_data = req_tdata;
               emit_last = req_tlast;
            end
            rsp_data_in  = emit_data ^ ks_byte;
            rsp_last_in  = emit_last;
            rsp_valid_in = 1'b1;
            // the rest of the word is dropped at the end of a message
            pos_in       = emit_last ? 4'd8 : pos_ff + 4'd1;
         end
         mtks_pkg::OP_SEED_INIT: begin
            mem_we    = 1'b1;
            mem_addr  = 9'd0;
            mem_wdata = seed_ff;
            prev_in   = seed_ff;
            sidx_in   = 9'd1;
            k_in      = 9'd0;
            pos_in    = 4'd8;
         end
         mtks_pkg::OP_SEED_MUL0: begin
            mul_a = seed_x[31:0];
            mul_b = INIT_MUL[31:0];
            x_in  = seed_x;
         end
         mtks_pkg::OP_SEED_MUL1: begin
            mul_a  = x_ff[63:32];
            mul_b  = INIT_MUL[31:0];
            acc_in = prod_ff;
         end
         mtks_pkg::OP_SEED_MUL2: begin
            mul_a  = x_ff[31:0];
            mul_b  = INIT_MUL[63:32];
            acc_in = acc_ff + {prod_ff[31:0], 32'h0};
         end
         mtks_pkg::OP_SEED_MUL3: begin
            mem_we    = 1'b1;
            mem_addr  = sidx_ff;
            mem_wdata = acc_ff + {prod_ff[31:0], 32'h0} + {55'h0, sidx_ff};
            prev_in   = mem_wdata;
            sidx_in   = sidx_ff + 9'd1;
         end
         mtks_pkg::OP_FETCH0: begin
            mem_addr = k_ff;
         end
         mtks_pkg::OP_FETCH1: begin
            a_in     = rdata_ff;
            mem_addr = k_next;
         end
         mtks_pkg::OP_FETCH2: begin
            b_in     = rdata_ff;
            mem_addr = k_mid;
         end
         mtks_pkg::OP_FETCH3: begin
            // in-place twist of one word, same order as a full pass
            mem_we    = 1'b1;
            mem_addr  = k_ff;
            mem_wdata = rdata_ff ^ twist_xa;
            tw_in     = mem_wdata;
         end
         mtks_pkg::OP_FETCH4: begin
            cur_in = temper(tw_ff);
            pos_in = 4'd0;
            k_in   = k_next;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= 64'h0;
         pos_ff       <= 4'd8;
         k_ff         <= 9'd0;
         sidx_ff      <= 9'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         pos_ff       <= pos_in;
         k_ff         <= k_in;
         sidx_ff      <= sidx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff      <= prev_in;
      x_ff         <= x_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      tw_ff        <= tw_in;
      cur_ff       <= cur_in;
      hold_data_ff <= hold_data_in;
      hold_last_ff <= hold_last_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule
`default_nettype wire

FILE: hw/rtl/mt64_keystream_xor.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mt64_keystream_xor
// Byte stream cipher: each byte is xored with keystream taken from a 64-bit
// Mersenne Twister variant, least significant byte of each word first.
// ---------------------------------------------------------------------------
// usage:
//   req_* carries one byte per transaction, req_tlast ends a message.
//   rsp_* returns the xored byte with the same tlast, one per transaction.
//   csr_* writes the 64-bit seed; write it only between messages.
// latency and throughput:
//   a byte from the current word: result in the cycle after acceptance, and a
//   new byte can be taken every cycle unless the output register is held.
//   first byte of a word: FETCH0 to FETCH4 then EMIT, set by the single-port
//   state memory (three reads and one write per twisted word) and tempering.
//   first byte of a message: reseed sweep of SEED_INIT, then SEED_MUL0 to
//   SEED_MUL3 per word (one shared 32x32 multiplier), before the fetch above.
// reset:
//   seed clears to zero and the first byte after reset always reseeds.
// stalls:
//   a result waits in the output register while rsp_tready is low; a new
//   request is taken only once that register is free or being emptied.
// ---------------------------------------------------------------------------
module mt64_keystream_xor (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_in
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] data_out
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [63:0] csr_data      // seed
);

   mtks_pkg::op_type     op;
   mtks_pkg::status_type status;

   mtks_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .op         (op)
   );

   mtks_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire
